// File: src/swv_pkg.sv
// shared types, constants and field widths for the sliding window variance core
// no dependencies; imported by swv_div and sliding_window_variance_core

package swv_pkg;

   // default sizes handed to the top level parameters
   localparam int CHANNELS_DEF   = 8;
   localparam int MAX_WINDOW_DEF = 64;

   // transaction field widths
   localparam int CMD_W     = 2;
   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 16;
   localparam int VAR_W     = 47;
   localparam int MEAN_W    = 32;
   localparam int COUNT_W   = 7;
   localparam int WLEN_W    = 7;

   // stream packing
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = CMD_W + CHAN_W;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = CHAN_W;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // serial divider: four quotient bits per cycle over a 64-bit dividend
   localparam int DIV_BITS      = 64;
   localparam int DIV_STEP      = 4;
   localparam int DIV_RUN_LONG  = DIV_BITS / DIV_STEP;
   localparam int DIV_RUN_SHORT = 32 / DIV_STEP;
   localparam int DIV_CNT_W     = 5;

   // result limits
   localparam logic [MEAN_W-1:0] MEAN_MIN = 32'h8000_0000;
   localparam logic [MEAN_W-1:0] MEAN_MAX = 32'h7FFF_0000;
   localparam logic [VAR_W-1:0]  VAR_MAX  = 47'h4000_0000_0000;

   // divider launch request
   typedef struct packed {
      logic start;
      logic long_run;
   } div_ctrl_type;

endpackage

// File: src/swv_div.sv
// radix-16 restoring divider, unsigned 64-bit dividend by a narrow divisor
// depends on swv_pkg for the run lengths and the launch request struct

module swv_div
   import swv_pkg::*;
#(
   parameter int DIVISOR_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [DIV_BITS-1:0]  dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [DIV_BITS-1:0]  quotient
);

   logic [DIV_BITS-1:0]  dq_ff, dq_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] run_ff, run_in;
   logic                 done_ff, done_in;

   logic [DIV_BITS-1:0]  dq_step;
   logic [DIVISOR_W-1:0] rem_step;
   logic [DIVISOR_W:0]   trial;

   // four shift and subtract steps; dividend bits leave at the top, quotient bits enter below
   always_comb begin
      dq_step  = dq_ff;
      rem_step = rem_ff;
      trial    = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_step, dq_step[DIV_BITS-1]};
         if (trial >= {1'b0, dvs_ff}) begin
            trial   = trial - {1'b0, dvs_ff};
            dq_step = {dq_step[DIV_BITS-2:0], 1'b1};
         end else begin
            dq_step = {dq_step[DIV_BITS-2:0], 1'b0};
         end
         rem_step = trial[DIVISOR_W-1:0];
      end
   end

   // launch and run control
   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
         run_in = ctrl.long_run ? DIV_CNT_W'(DIV_RUN_LONG) : DIV_CNT_W'(DIV_RUN_SHORT);
      end else if (run_ff != '0) begin
         dq_in   = dq_step;
         rem_in  = rem_step;
         run_in  = run_ff - 1'b1;
         done_in = (run_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (run_ff != '0);
   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// File: src/sliding_window_variance_core.sv
// top level of the multi-channel sliding window variance core
// depends on swv_pkg and swv_div (the shared serial divider)

// Each request transaction carries a command and a channel in req_tuser and a signed 16-bit
// sample in req_tdata. An add appends the sample to the channel window: while the window
// fills, the mean and the sum of squared deviations follow Welford's incremental update, and
// once full the oldest sample is retired by the sliding update. Clear empties one channel,
// query reports without changing anything, and writing window_length empties every channel.
// Every request gives one response transaction with variance (Q.16, truncated, floored at 0,
// capped at 2^46), mean (Q.16) and fill count. One request is worked on at a time. A clear
// or a request for an out-of-range channel goes straight to its response; for an add or a
// query, most of the work is done by the single shared serial divider, which
// retires four quotient bits a cycle for the mean step and for the final variance divide;
// one 34x32 multiplier and a 64-bit accumulate fill in the rest. A pending response does not
// block acceptance of the next request. No clearing pass is needed after reset.

module sliding_window_variance_core
   import swv_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] sample
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [1:0] command, [4:2] channel
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [46:0] variance, [78:47] mean,
                                               // [85:79] fill_count, [87:86] zero
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // [2:0] channel_out
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW       = $clog2(MAX_WINDOW);
   localparam int CW       = $clog2(MAX_WINDOW + 1);
   localparam int REC_W    = PW + CW + MEAN_W + 64;
   localparam int WS_DEPTH = CHANNELS * (2 ** PW);

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_DECIDE = 4'd2;
   localparam logic [3:0] ST_OLD    = 4'd3;
   localparam logic [3:0] ST_MDIV   = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_ACC    = 4'd6;
   localparam logic [3:0] ST_VSTART = 4'd7;
   localparam logic [3:0] ST_VDIV   = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   // control state
   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       wl_ff, wl_in;
   logic [CHANNELS-1:0] vld_ff, vld_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // working registers of the transaction in flight
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [MEAN_W-1:0]   mnew_ff, mnew_in;
   logic [63:0]         sum_ff, sum_in;
   logic [32:0]         delta_ff, delta_in;
   logic [SAMPLE_W-1:0] old_ff, old_in;
   logic                fill_ff, fill_in;
   logic                neg_ff, neg_in;
   logic [63:0]         prod_ff, prod_in;
   logic [VAR_W-1:0]    var_ff, var_in;

   // response registers
   logic [CHAN_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic [VAR_W-1:0]    rsp_var_ff, rsp_var_in;
   logic [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // per-channel record store and window store
   logic [REC_W-1:0]    rec_mem [CHANNELS];
   logic [REC_W-1:0]    rec_rd_ff;
   logic                rec_we;
   logic [CH_W-1:0]     rec_raddr;
   logic [SAMPLE_W-1:0] ws_mem [WS_DEPTH];
   logic [SAMPLE_W-1:0] ws_rd_ff;
   logic                ws_we;
   logic [CH_W+PW-1:0]  ws_waddr;
   logic [CH_W+PW-1:0]  ws_raddr;

   // divider hookup
   div_ctrl_type        div_ctrl;
   logic [63:0]         div_dividend;
   logic [CW-1:0]       div_divisor;
   logic                div_busy;
   logic                div_done;
   logic [63:0]         div_quo;

   // request decode
   logic [CMD_W-1:0]    req_cmd;
   logic [CHAN_W-1:0]   req_chan;
   logic                req_in_range;
   logic [CH_W-1:0]     req_idx;
   logic [CH_W-1:0]     chan_idx;
   logic                req_fire;

   // datapath terms
   logic [31:0]         s_q16;
   logic [32:0]         fill_d;
   logic [16:0]         slide_diff;
   logic [32:0]         slide_delta;
   logic [16:0]         slide_sum;
   logic [CW:0]         wp_sum;
   logic [CW:0]         wp_wrap;
   logic [PW-1:0]       wp;
   logic [PW:0]         ptr_inc;
   logic [33:0]         quo_signed;
   logic [33:0]         mean_raw;
   logic [32:0]         fill_b;
   logic [35:0]         slide_f;
   logic [35:0]         slide_f_neg;
   logic [33:0]         mul_a;
   logic [31:0]         mul_b;
   logic [65:0]         prod_full;
   logic [63:0]         addend;
   logic [63:0]         addend_signed;
   logic [63:0]         sum_new;
   logic [31:0]         wl_req;
   logic [WLEN_W-1:0]   wl_raw;
   logic                csr_wr;

   assign req_cmd      = req_tuser[CMD_W-1:0];
   assign req_chan     = req_tuser[CMD_W+CHAN_W-1:CMD_W];
   assign req_in_range = (32'(req_chan) < 32'(CHANNELS));
   assign req_idx      = CH_W'(req_chan);
   assign chan_idx     = CH_W'(chan_ff);
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;

   // register port: one register, window_length, clamped into 1..MAX_WINDOW
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_WINDOW_LENGTH);
   assign wl_raw     = csr_pwdata[WLEN_W-1:0];
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_LENGTH) ? CSR_DATA_W'(wl_ff) : '0;

   always_comb begin
      if (wl_raw == '0) begin
         wl_req = 32'd1;
      end else if (32'(wl_raw) > 32'(MAX_WINDOW)) begin
         wl_req = 32'(MAX_WINDOW);
      end else begin
         wl_req = 32'(wl_raw);
      end
   end

   // arithmetic terms shared by the sequencer states
   assign s_q16       = {smp_ff, 16'h0000};
   assign fill_d      = {s_q16[31], s_q16} - {mean_ff[31], mean_ff};
   assign slide_diff  = {smp_ff[15], smp_ff} - {ws_rd_ff[15], ws_rd_ff};
   assign slide_delta = {{16{slide_diff[16]}}, slide_diff};
   assign slide_sum   = {smp_ff[15], smp_ff} + {old_ff[15], old_ff};
   assign wp_sum      = {1'b0, CW'(ptr_ff)} + {1'b0, cnt_ff};
   assign wp_wrap     = wp_sum - {1'b0, wl_ff};
   assign wp          = (wp_sum >= {1'b0, wl_ff}) ? wp_wrap[PW-1:0] : wp_sum[PW-1:0];
   assign ptr_inc     = {1'b0, ptr_ff} + 1'b1;

   // mean update from the signed quotient
   assign quo_signed = delta_ff[32] ? (34'd0 - {2'b00, div_quo[31:0]})
                                    : {2'b00, div_quo[31:0]};
   assign mean_raw   = {{2{mean_ff[31]}}, mean_ff} + quo_signed;

   // multiplier operands: filling uses d and S - m', sliding uses f and s - o
   assign fill_b      = {s_q16[31], s_q16} - {mnew_ff[31], mnew_ff};
   assign slide_f     = {{3{slide_sum[16]}}, slide_sum, 16'h0000}
                        - {{4{mean_ff[31]}}, mean_ff} - {{4{mnew_ff[31]}}, mnew_ff};
   assign slide_f_neg = -slide_f;
   assign mul_a       = fill_ff ? {2'b00, mag33(fill_b)}
                                : (slide_f[35] ? slide_f_neg[33:0] : slide_f[33:0]);
   assign mul_b       = mag33(delta_ff);
   assign prod_full   = 66'(mul_a) * 66'(mul_b);

   // accumulate; the filling term is scaled down by 2^16 before the sign goes back on
   assign addend        = fill_ff ? {16'h0000, prod_ff[63:16]} : prod_ff;
   assign addend_signed = neg_ff ? (64'd0 - addend) : addend;
   assign sum_new       = sum_ff + addend_signed;

   assign rec_raddr = req_in_range ? req_idx : '0;
   assign ws_raddr  = {chan_idx, ptr_ff};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      wl_in         = wl_ff;
      vld_in        = vld_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd_in        = cmd_ff;
      chan_in       = chan_ff;
      smp_in        = smp_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      mean_in       = mean_ff;
      mnew_in       = mnew_ff;
      sum_in        = sum_ff;
      delta_in      = delta_ff;
      old_in        = old_ff;
      fill_in       = fill_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      var_in        = var_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rec_we        = 1'b0;
      ws_we         = 1'b0;
      ws_waddr      = {chan_idx, wp};
      div_ctrl      = '{start: 1'b0, long_run: 1'b0};
      div_dividend  = sum_ff;
      div_divisor   = cnt_ff;

      // a register write empties every channel
      if (csr_wr) begin
         wl_in  = wl_req[CW-1:0];
         vld_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_cmd;
               chan_in = req_chan;
               smp_in  = req_tdata[SAMPLE_W-1:0];
               var_in  = '0;
               mean_in = '0;
               cnt_in  = '0;
               if (!req_in_range) begin
                  state_in = ST_OUT;
               end else if (req_cmd == CMD_CLEAR) begin
                  vld_in[req_idx] = 1'b0;
                  state_in        = ST_OUT;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // a channel that is not valid reads as empty
            if (vld_ff[chan_idx]) begin
               {ptr_in, cnt_in, mean_in, sum_in} = rec_rd_ff;
            end else begin
               ptr_in  = '0;
               cnt_in  = '0;
               mean_in = '0;
               sum_in  = '0;
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cmd_ff != CMD_ADD) begin
               state_in = ST_VSTART;
            end else if (cnt_ff < wl_ff) begin
               // filling: store the sample behind the newest, divide d by the new count
               ws_we        = 1'b1;
               ws_waddr     = {chan_idx, wp};
               cnt_in       = cnt_ff + 1'b1;
               delta_in     = fill_d;
               fill_in      = 1'b1;
               div_ctrl     = '{start: 1'b1, long_run: 1'b0};
               div_dividend = {mag33(fill_d), 32'h0};
               div_divisor  = cnt_ff + 1'b1;
               state_in     = ST_MDIV;
            end else begin
               fill_in  = 1'b0;
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            // sliding: oldest sample is out of the store, overwrite it in place
            ws_we        = 1'b1;
            ws_waddr     = {chan_idx, ptr_ff};
            old_in       = ws_rd_ff;
            delta_in     = slide_delta;
            ptr_in       = (32'(ptr_inc) == 32'(wl_ff)) ? '0 : ptr_inc[PW-1:0];
            div_ctrl     = '{start: 1'b1, long_run: 1'b0};
            div_dividend = {mag33(slide_delta), 32'h0} << 16;
            div_divisor  = wl_ff;
            state_in     = ST_MDIV;
         end
         ST_MDIV: begin
            if (div_done) begin
               if ($signed(mean_raw) < $signed({2'b11, MEAN_MIN})) begin
                  mnew_in = MEAN_MIN;
               end else if ($signed(mean_raw) > $signed({2'b00, MEAN_MAX})) begin
                  mnew_in = MEAN_MAX;
               end else begin
                  mnew_in = mean_raw[MEAN_W-1:0];
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[63:0];
            neg_in   = delta_ff[32] ^ (fill_ff ? fill_b[32] : slide_f[35]);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            rec_we              = 1'b1;
            vld_in[chan_idx]    = 1'b1;
            mean_in             = mnew_ff;
            sum_in              = sum_new;
            state_in            = ST_VSTART;
         end
         ST_VSTART: begin
            if ((cnt_ff == '0) || sum_ff[63]) begin
               var_in   = '0;
               state_in = ST_OUT;
            end else begin
               div_ctrl     = '{start: 1'b1, long_run: 1'b1};
               div_dividend = sum_ff;
               div_divisor  = cnt_ff;
               state_in     = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (div_done) begin
               var_in   = (div_quo > 64'(VAR_MAX)) ? VAR_MAX : div_quo[VAR_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the response register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_chan_in   = chan_ff;
               rsp_var_in    = var_ff;
               rsp_mean_in   = mean_ff;
               rsp_cnt_in    = COUNT_W'(cnt_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wl_ff         <= CW'(MAX_WINDOW);
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wl_ff         <= wl_in;
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chan_ff     <= chan_in;
      smp_ff      <= smp_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      mean_ff     <= mean_in;
      mnew_ff     <= mnew_in;
      sum_ff      <= sum_in;
      delta_ff    <= delta_in;
      old_ff      <= old_in;
      fill_ff     <= fill_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      var_ff      <= var_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // channel record store, read registered at the requested channel
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[chan_idx] <= {ptr_ff, cnt_ff, mnew_ff, sum_new};
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   // sample window store
   always_ff @(posedge clock) begin
      if (ws_we) begin
         ws_mem[ws_waddr] <= smp_ff;
      end
      ws_rd_ff <= ws_mem[ws_raddr];
   end

   swv_div #(
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tdata  = {2'b00, rsp_cnt_ff, rsp_mean_ff, rsp_var_ff};

   // the divider is only launched when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_busy)
      else $error("divider launched while busy");

   // divider results only arrive while the sequencer waits for them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MDIV || state_ff == ST_VDIV))
      else $error("divider result with no consumer");

   // a loaded channel never holds more samples than the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (cnt_ff <= wl_ff && 32'(ptr_ff) < 32'(wl_ff)))
      else $error("channel record outside the window");

   // window length stays in its legal range
   a_wlen_range: assert property (@(posedge clock) disable iff (reset)
      (wl_ff != '0) && (32'(wl_ff) <= 32'(MAX_WINDOW)))
      else $error("window length out of range");

endmodule
